### rtl/core/text_to_utf8_transcoder_defines.svh
// Assertion macros shared by the transcoder RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using module.
`ifndef TEXT_TO_UTF8_TRANSCODER_DEFINES_SVH
`define TEXT_TO_UTF8_TRANSCODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define TUTF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define TUTF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TUTF_ASSERT(lbl, prop, msg)
`define TUTF_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/core/tutf_pkg.sv
// Types, constants and UTF-8 encode helpers for the text to UTF-8 transcoder.
// No dependencies; used by every module of the block.
package tutf_pkg;

	// default depth of the job queue between front and back
	localparam int TUTF_QUEUE_DEPTH = 4;

	// encoding selector values carried by the body start byte
	localparam logic [7:0] ENC_LATIN1    = 8'h00;
	localparam logic [7:0] ENC_UTF16_BOM = 8'h01;
	localparam logic [7:0] ENC_UTF16_BE  = 8'h02;
	localparam logic [7:0] ENC_UTF8      = 8'h03;

	// byte-order mark bytes
	localparam logic [7:0] BOM_FE = 8'hFE;
	localparam logic [7:0] BOM_FF = 8'hFF;

	// surrogate handling: high surrogates have this top-6-bit prefix
	localparam logic [5:0]  SURR_HIGH_PREFIX = 6'b110110;
	// 0x10000 - 0xDC00, folded into the pair combine
	localparam logic [20:0] PAIR_OFFSET = 21'h002400;

	// whitespace codes folded to space
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       body_start;
		logic       body_end;
	} text_word_t;

	// output word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} utf_word_t;

	// one queued job: up to four UTF-8 bytes, bytes[0] goes out first
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
	} job_t;

	// tab, CR and LF become space
	function automatic logic [7:0] fold_ws(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b == CH_TAB || b == CH_LF || b == CH_CR) begin
			r = CH_SPACE;
		end
		return r;
	endfunction

	// a single raw byte as a job
	function automatic job_t raw_job(input logic [7:0] b);
		job_t j;
		j = '0;
		j.count    = 3'd1;
		j.bytes[0] = fold_ws(b);
		return j;
	endfunction

	// UTF-8 encode of a code point; zero yields an empty job
	function automatic job_t encode_code(input logic [20:0] cp);
		job_t j;
		j = '0;
		if (cp == '0) begin
			j.count = 3'd0;
		end else if (cp < 21'h80) begin
			j = raw_job(cp[7:0]);
		end else if (cp < 21'h800) begin
			j.count    = 3'd2;
			j.bytes[0] = {3'b110, cp[10:6]};
			j.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			j.count    = 3'd3;
			j.bytes[0] = {4'b1110, cp[15:12]};
			j.bytes[1] = {2'b10, cp[11:6]};
			j.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			j.count    = 3'd4;
			j.bytes[0] = {5'b11110, cp[20:18]};
			j.bytes[1] = {2'b10, cp[17:12]};
			j.bytes[2] = {2'b10, cp[11:6]};
			j.bytes[3] = {2'b10, cp[5:0]};
		end
		return j;
	endfunction

endpackage

### rtl/core/tutf_queue.sv
// Small register FIFO of encode jobs between the front and back ends.
// Depends on tutf_pkg and the assertion macro header.
`include "text_to_utf8_transcoder_defines.svh"
module tutf_queue #(
	parameter int DEPTH = tutf_pkg::TUTF_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tutf_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output tutf_pkg::job_t head_job
);
	import tutf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	// payload store
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`TUTF_NEVER(a_push_when_full, push && full && !pop, "job queue overflow")
	`TUTF_NEVER(a_pop_when_empty, pop && !head_valid, "job queue underflow")

endmodule

### rtl/core/tutf_front.sv
// Front end: accepts text words, tracks body/encoding state, builds UTF-8 jobs.
// Depends on tutf_pkg and the assertion macro header.
`include "text_to_utf8_transcoder_defines.svh"
module tutf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  tutf_pkg::text_word_t text_word,
	input  logic                q_full,
	output logic                q_push,
	output tutf_pkg::job_t      q_job
);
	import tutf_pkg::*;

	typedef enum logic [1:0] {
		MODE_STOPPED,
		MODE_LATIN1,
		MODE_UTF8,
		MODE_UTF16
	} mode_t;

	mode_t       mode_q, mode_n;
	logic        big_q, big_n;
	logic        half_q, half_n;
	logic [7:0]  held_q, held_n;
	logic        mark_q, mark_n;
	logic        hv_q, hv_n;
	logic [15:0] hu_q, hu_n;
	job_t        job;
	logic [7:0]  b;
	logic [15:0] unit;
	logic        is_mark;
	logic [20:0] pair_cp;
	logic        accept;

	assign b          = text_word.data_byte;
	assign text_stall = q_full;
	assign accept     = text_valid && !text_stall;
	assign q_push     = accept && (job.count != 3'd0);
	assign q_job      = job;

	// unit assembly and surrogate combine
	assign unit    = big_q ? {held_q, b} : {b, held_q};
	assign is_mark = mark_q && ((held_q == BOM_FE && b == BOM_FF) ||
		(held_q == BOM_FF && b == BOM_FE));
	assign pair_cp = {1'b0, hu_q[9:0], 10'b0} + {5'b0, unit} + PAIR_OFFSET;

	// next state and job for the word on the port
	always_comb begin
		mode_n = mode_q;
		big_n  = big_q;
		half_n = half_q;
		held_n = held_q;
		mark_n = mark_q;
		hv_n   = hv_q;
		hu_n   = hu_q;
		job    = '0;
		if (text_word.body_start) begin
			half_n = 1'b0;
			hv_n   = 1'b0;
			case (b)
				ENC_LATIN1: mode_n = MODE_LATIN1;
				ENC_UTF8:   mode_n = MODE_UTF8;
				default:    mode_n = MODE_UTF16;
			endcase
			big_n  = (b == ENC_UTF16_BE);
			mark_n = (b == ENC_UTF16_BOM);
		end else begin
			case (mode_q)
				MODE_LATIN1: begin
					if (b == 8'h00) begin
						mode_n = MODE_STOPPED;
					end else begin
						job = encode_code({13'b0, b});
					end
				end
				MODE_UTF8: begin
					if (b == 8'h00) begin
						mode_n = MODE_STOPPED;
					end else begin
						job = raw_job(b);
					end
				end
				MODE_UTF16: begin
					if (!half_q) begin
						held_n = b;
						half_n = 1'b1;
					end else begin
						half_n = 1'b0;
						mark_n = 1'b0;
						if (is_mark) begin
							big_n = (held_q == BOM_FE);
						end else if (hv_q) begin
							hv_n = 1'b0;
							job  = encode_code(pair_cp);
						end else if (unit == 16'h0000) begin
							mode_n = MODE_STOPPED;
						end else if (unit[15:10] == SURR_HIGH_PREFIX) begin
							hu_n = unit;
							hv_n = 1'b1;
						end else begin
							job = encode_code({5'b0, unit});
						end
					end
				end
				default: begin
					mode_n = MODE_STOPPED;
				end
			endcase
		end
		// a high surrogate left open at body end goes out alone
		if (text_word.body_end) begin
			if (mode_n == MODE_UTF16 && hv_n) begin
				job = encode_code({5'b0, hu_n});
			end
			mode_n = MODE_STOPPED;
		end
		// stopping drops any partial unit, mark check or pending surrogate
		if (mode_n == MODE_STOPPED) begin
			half_n = 1'b0;
			mark_n = 1'b0;
			hv_n   = 1'b0;
		end
	end

	// body state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STOPPED;
			big_q  <= 1'b0;
			half_q <= 1'b0;
			held_q <= '0;
			mark_q <= 1'b0;
			hv_q   <= 1'b0;
			hu_q   <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			big_q  <= big_n;
			half_q <= half_n;
			held_q <= held_n;
			mark_q <= mark_n;
			hv_q   <= hv_n;
			hu_q   <= hu_n;
		end
	end

	`TUTF_ASSERT(a_stopped_clean, mode_q == MODE_STOPPED |-> !half_q && !hv_q && !mark_q,
		"stopped body still holds decode state")
	`TUTF_ASSERT(a_held_is_high, hv_q |-> hu_q[15:10] == SURR_HIGH_PREFIX,
		"pending unit is not a high surrogate")

endmodule

### rtl/core/tutf_back.sv
// Back end: walks the bytes of each queued job into the output register.
// Depends on tutf_pkg and the assertion macro header.
`include "text_to_utf8_transcoder_defines.svh"
module tutf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  tutf_pkg::job_t     q_job,
	output logic               q_pop,
	output logic               utf_valid,
	input  logic               utf_stall,
	output tutf_pkg::utf_word_t utf_word
);
	import tutf_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	utf_word_t  word_q;
	logic       load;
	logic       last;

	// output register takes a new byte when empty or being drained
	assign load      = q_valid && (!valid_q || !utf_stall);
	assign last      = ({1'b0, idx_q} == q_job.count - 3'd1);
	assign q_pop     = load && last;
	assign utf_valid = valid_q;
	assign utf_word  = word_q;

	// byte index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (!utf_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			word_q.out_byte <= q_job.bytes[idx_q];
			word_q.run_last <= last;
		end
	end

	`TUTF_ASSERT(a_mid_job_has_head, idx_q != 2'd0 |-> q_valid,
		"job queue emptied in the middle of a job")

endmodule

### rtl/core/text_to_utf8_transcoder.sv
// Top level of the text body to UTF-8 transcoder.
// Depends on tutf_pkg, tutf_front, tutf_queue and tutf_back.
//
// Usage:
//   text channel: one body byte per word (data_byte, body_start, body_end).
//     The word flagged body_start carries the encoding selector: 0 Latin-1,
//     3 UTF-8, 1 UTF-16 with optional byte-order mark, 2 UTF-16 big-endian,
//     anything else UTF-16 little-endian.
//   utf channel: one UTF-8 byte per word; run_last marks the last byte
//     produced by one input word. Words producing nothing send nothing.
//   Path: an accepted input word's job is written into the queue at the
//     accepting edge; its bytes then go on to the output register.
//   Throughput: one input word per cycle while the job queue has room; the
//     output register sends one byte per cycle while utf_stall is low and sets
//     the sustained rate; a word yields 0 to 4 UTF-8 bytes.
//   Stall: a stall on the utf channel holds the output register; the queue
//     of QUEUE_DEPTH jobs keeps taking input until it fills, then text_stall
//     rises.
//   Reset: arst_n clears the body state (no body open), the queue and the
//     output valid; bytes before the first body_start are ignored.
module text_to_utf8_transcoder #(
	parameter int QUEUE_DEPTH = tutf_pkg::TUTF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  tutf_pkg::text_word_t text_word,
	output logic                utf_valid,
	input  logic                utf_stall,
	output tutf_pkg::utf_word_t utf_word
);
	import tutf_pkg::*;

	logic q_full;
	logic q_push;
	job_t q_push_job;
	logic q_pop;
	logic q_head_valid;
	job_t q_head_job;

	// decode and classify
	tutf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_word  (text_word),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (q_push_job)
	);

	// job queue
	tutf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_job   (q_head_job)
	);

	// byte serializer
	tutf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_head_valid),
		.q_job     (q_head_job),
		.q_pop     (q_pop),
		.utf_valid (utf_valid),
		.utf_stall (utf_stall),
		.utf_word  (utf_word)
	);

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_to_utf8_transcoder: directed bodies, then random traffic.
// Depends on tutf_pkg and the transcoder RTL; predicts every UTF-8 byte and checks it in order.
module tb;
	import tutf_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;

	typedef enum logic [1:0] {
		MODE_STOPPED,
		MODE_LATIN1,
		MODE_UTF8,
		MODE_UTF16
	} text_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       text_valid = 1'b0;
	logic       text_stall;
	text_word_t text_word = '0;
	logic       utf_valid;
	logic       utf_stall = 1'b0;
	utf_word_t  utf_word;

	// pacing knobs: most cycles either side waits per word
	int send_gap_max = 9;
	int sink_gap_max = 9;
	int word_total = 0;
	int fault_count = 0;
	int idle_cycles = 0;

	// predicted output words, oldest first
	utf_word_t utf8_bytes_due[$];
	// bytes of the body being built by the random generator
	logic [7:0] body_bytes[$];

	// predictor state
	text_mode_t  text_mode_q = MODE_STOPPED;
	logic        big_endian_q = 1'b0;
	logic        half_unit_q = 1'b0;
	logic [7:0]  held_byte_q = 8'h00;
	logic        mark_pending_q = 1'b0;
	logic        high_valid_q = 1'b0;
	logic [15:0] high_unit_q = 16'h0000;
	logic [7:0]  step_bytes[4];
	int          step_count;

	text_to_utf8_transcoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_word (text_word),
		.utf_valid (utf_valid),
		.utf_stall (utf_stall),
		.utf_word  (utf_word)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// one output byte, whitespace folded, at most four per input word
	function void emit_byte(input logic [7:0] b);
		logic [7:0] c;
		c = b;
		if (step_count >= 4) return;
		if (c == CH_TAB || c == CH_LF || c == CH_CR) c = CH_SPACE;
		step_bytes[step_count] = c;
		step_count++;
	endfunction

	// UTF-8 encoding of one code point; zero emits nothing
	function void emit_code(input logic [31:0] cp);
		if (cp == 0) return;
		if (cp < 32'h80) begin
			emit_byte(cp[7:0]);
		end else if (cp < 32'h800) begin
			emit_byte({3'b110, cp[10:6]});
			emit_byte({2'b10, cp[5:0]});
		end else if (cp < 32'h10000) begin
			emit_byte({4'b1110, cp[15:12]});
			emit_byte({2'b10, cp[11:6]});
			emit_byte({2'b10, cp[5:0]});
		end else begin
			// four-byte form takes bits 21..0
			emit_byte(8'hF0 | {4'h0, cp[21:18]});
			emit_byte({2'b10, cp[17:12]});
			emit_byte({2'b10, cp[11:6]});
			emit_byte({2'b10, cp[5:0]});
		end
	endfunction

	function void close_body();
		text_mode_q = MODE_STOPPED;
		half_unit_q = 1'b0;
		mark_pending_q = 1'b0;
		high_valid_q = 1'b0;
	endfunction

	// UTF-16 byte: pair bytes into units, check the mark, join surrogates
	function void utf16_byte_in(input logic [7:0] b);
		logic [7:0]  a;
		logic [31:0] unit;
		logic [31:0] cp;
		if (!half_unit_q) begin
			held_byte_q = b;
			half_unit_q = 1'b1;
			return;
		end
		half_unit_q = 1'b0;
		a = held_byte_q;
		if (mark_pending_q) begin
			mark_pending_q = 1'b0;
			if (a == BOM_FE && b == BOM_FF) begin
				big_endian_q = 1'b1;
				return;
			end
			if (a == BOM_FF && b == BOM_FE) begin
				big_endian_q = 1'b0;
				return;
			end
		end
		unit = big_endian_q ? {16'h0, a, b} : {16'h0, b, a};
		if (high_valid_q) begin
			// any unit completes the pair, with 32-bit wrap
			cp = 32'h10000 + (({16'h0, high_unit_q} - 32'hD800) << 10) + (unit - 32'hDC00);
			high_valid_q = 1'b0;
			emit_code(cp);
			return;
		end
		if (unit == 0) begin
			close_body();
			return;
		end
		if (unit >= 32'hD800 && unit < 32'hDC00) begin
			high_unit_q = unit[15:0];
			high_valid_q = 1'b1;
			return;
		end
		emit_code(unit);
	endfunction

	// expected output words for one accepted text word
	function void transcode_word(input text_word_t w);
		utf_word_t r;
		step_count = 0;
		if (w.body_start) begin
			close_body();
			if (w.data_byte == ENC_LATIN1) text_mode_q = MODE_LATIN1;
			else if (w.data_byte == ENC_UTF8) text_mode_q = MODE_UTF8;
			else text_mode_q = MODE_UTF16;
			big_endian_q = (w.data_byte == ENC_UTF16_BE);
			mark_pending_q = (w.data_byte == ENC_UTF16_BOM);
		end else if (text_mode_q == MODE_LATIN1) begin
			if (w.data_byte == 8'h00) close_body();
			else emit_code({24'h0, w.data_byte});
		end else if (text_mode_q == MODE_UTF8) begin
			if (w.data_byte == 8'h00) close_body();
			else emit_byte(w.data_byte);
		end else if (text_mode_q == MODE_UTF16) begin
			utf16_byte_in(w.data_byte);
		end
		if (w.body_end) begin
			// a dangling high surrogate goes out alone
			if (text_mode_q == MODE_UTF16 && high_valid_q) emit_code({16'h0, high_unit_q});
			close_body();
		end
		for (int i = 0; i < step_count; i++) begin
			r.out_byte = step_bytes[i];
			r.run_last = (i == step_count - 1);
			utf8_bytes_due.push_back(r);
		end
	endfunction

	// ---------------------------------------------------------------
	// monitors
	// ---------------------------------------------------------------

	// predict on every accepted text word
	always @(posedge clk) begin
		if (arst_n && text_valid && !text_stall) transcode_word(text_word);
	end

	// compare each accepted output word with the oldest prediction
	always @(posedge clk) begin : check_utf_words
		utf_word_t due;
		if (arst_n && utf_valid && !utf_stall) begin
			if (utf8_bytes_due.size() == 0) begin
				$display("%0t: unexpected word out_byte=%h run_last=%b", $time,
					utf_word.out_byte, utf_word.run_last);
				fault_count++;
			end else begin
				due = utf8_bytes_due.pop_front();
				if (utf_word.out_byte !== due.out_byte) begin
					$display("%0t: out_byte expected %h got %h", $time,
						due.out_byte, utf_word.out_byte);
					fault_count++;
				end
				if (utf_word.run_last !== due.run_last) begin
					$display("%0t: run_last expected %b got %b (out_byte %h)", $time,
						due.run_last, utf_word.run_last, utf_word.out_byte);
					fault_count++;
				end
			end
		end
	end

	// output stall: a random hold-off before each word is taken
	initial begin : sink_pacing
		int n;
		forever begin
			n = $urandom_range(0, sink_gap_max);
			repeat (n) begin
				@(negedge clk);
				utf_stall <= 1'b1;
			end
			@(negedge clk);
			utf_stall <= 1'b0;
			do @(posedge clk); while (!utf_valid);
		end
	end

	// watchdog on cycles where no word moves on either side
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((text_valid && !text_stall) || (utf_valid && !utf_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("%0t: watchdog, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// one text word after a random gap; returns once accepted
	task automatic send_word(input logic [7:0] b, input logic st = 1'b0,
			input logic en = 1'b0);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_word <= {b, st, en};
		text_valid <= 1'b1;
		word_total++;
		do @(posedge clk); while (text_stall);
	endtask

	// hold off input until every predicted word has come out
	task automatic wait_for_output_drain();
		@(negedge clk);
		text_valid <= 1'b0;
		while (utf8_bytes_due.size() != 0) @(posedge clk);
	endtask

	function logic [7:0] pick_ws();
		case ($urandom_range(0, 2))
			0: return CH_TAB;
			1: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	function void add_unit(input logic [15:0] u, input bit big);
		if (big) begin
			body_bytes.push_back(u[15:8]);
			body_bytes.push_back(u[7:0]);
		end else begin
			body_bytes.push_back(u[7:0]);
			body_bytes.push_back(u[15:8]);
		end
	endfunction

	// one mostly well-formed body with random content, sometimes broken
	task automatic send_random_body();
		logic [7:0]  sel;
		logic [15:0] u;
		bit          big;
		bit          cut;
		int          units;
		int          r;
		body_bytes.delete();
		case ($urandom_range(0, 5))
			0: sel = ENC_LATIN1;
			1: sel = ENC_UTF8;
			2: sel = ENC_UTF16_BOM;
			3: sel = ENC_UTF16_BE;
			default: sel = 8'($urandom_range(4, 255));
		endcase
		units = $urandom_range(0, 6);
		if (sel == ENC_LATIN1 || sel == ENC_UTF8) begin
			repeat (units) begin
				r = $urandom_range(0, 19);
				if (r == 0) body_bytes.push_back(8'h00);
				else if (r == 1) body_bytes.push_back(pick_ws());
				else body_bytes.push_back(8'($urandom_range(1, 255)));
			end
		end else begin
			big = (sel == ENC_UTF16_BE);
			if (sel == ENC_UTF16_BOM) begin
				r = $urandom_range(0, 2);
				if (r == 1) begin
					add_unit(16'hFEFF, 1'b1);
					big = 1'b1;
				end else if (r == 2) begin
					add_unit(16'hFEFF, 1'b0);
				end
			end
			repeat (units) begin
				case ($urandom_range(0, 11))
					0: u = {8'h00, pick_ws()};
					1, 2: u = 16'($urandom_range(1, 16'h7F));
					3: u = 16'($urandom_range(16'h80, 16'h7FF));
					4: u = 16'($urandom_range(16'h800, 16'hD7FF));
					5: u = 16'($urandom_range(16'hE000, 16'hFFFF));
					6, 7, 8: begin
						add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), big);
						u = 16'($urandom_range(16'hDC00, 16'hDFFF));
					end
					9: u = 16'($urandom);
					10: u = 16'($urandom_range(16'hDC00, 16'hDFFF));
					default: u = 16'h0000;
				endcase
				add_unit(u, big);
			end
			r = $urandom_range(0, 5);
			if (r == 0) body_bytes.push_back(8'($urandom));
			else if (r == 1) add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), big);
		end
		// a body without its end gets cut off by the next start
		cut = ($urandom_range(0, 7) == 0);
		send_word(sel, 1'b1, body_bytes.size() == 0 && !cut);
		foreach (body_bytes[i])
			send_word(body_bytes[i], 1'b0, !cut && i == body_bytes.size() - 1);
		// stray words between bodies
		r = $urandom_range(0, 7);
		if (r == 0) begin
			send_word(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
		end else if (r == 1) begin
			send_word(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_random_bodies(input int words);
		int target;
		target = word_total + words;
		while (word_total < target) send_random_body();
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// Latin-1 and UTF-8 bodies: whitespace, top byte, NUL stop, data while stopped
	task automatic test_single_byte_text();
		send_word(ENC_LATIN1, 1'b1);
		send_word(CH_TAB);
		send_word(8'hFF);
		send_word(8'h00);
		send_word(8'h41);
		send_word(ENC_UTF8, 1'b1);
		send_word(CH_CR);
		send_word(8'hFF, 1'b0, 1'b1);
		// encoding word alone is a whole body
		send_word(ENC_UTF16_BE, 1'b1, 1'b1);
	endtask

	// both marks, restart mid-body, lone low surrogate, odd trailing byte
	task automatic test_byte_order_marks();
		send_word(ENC_UTF16_BOM, 1'b1);
		send_word(BOM_FF);
		send_word(BOM_FE);
		send_word(8'h00);
		send_word(8'hD8);
		send_word(ENC_UTF16_BOM, 1'b1);
		send_word(BOM_FE);
		send_word(BOM_FF);
		send_word(8'hDC);
		send_word(8'h00);
		send_word(8'h7F, 1'b0, 1'b1);
	endtask

	// pairs, a pair closed by a zero unit, high surrogate at body end
	task automatic test_surrogate_pairs();
		send_word(8'hFF, 1'b1);
		send_word(8'h00);
		send_word(8'hD8);
		send_word(8'h00);
		send_word(8'hDC);
		send_word(8'h3D);
		send_word(8'hD8);
		send_word(8'h00);
		send_word(8'h00);
		send_word(8'hFF);
		send_word(8'hDB, 1'b0, 1'b1);
	endtask

	task automatic test_mixed_idling();
		send_gap_max = 9;
		sink_gap_max = 9;
		run_random_bodies(45);
	endtask

	task automatic test_full_rate();
		send_gap_max = 0;
		sink_gap_max = 0;
		run_random_bodies(15);
	endtask

	// input at full rate into a slow sink so the job queue fills
	task automatic test_output_backpressure();
		send_gap_max = 0;
		sink_gap_max = 9;
		run_random_bodies(15);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_byte_text();
		test_byte_order_marks();
		test_surrogate_pairs();
		wait_for_output_drain();
		test_mixed_idling();
		wait_for_output_drain();
		test_full_rate();
		test_output_backpressure();
		wait_for_output_drain();
		repeat (8) @(posedge clk);

		if (utf8_bytes_due.size() != 0)
			$display("%0t: %0d predicted words never came out", $time, utf8_bytes_due.size());
		if (fault_count == 0 && utf8_bytes_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### text_to_utf8_transcoder.f
+incdir+rtl/core
rtl/core/tutf_pkg.sv
rtl/core/tutf_queue.sv
rtl/core/tutf_front.sv
rtl/core/tutf_back.sv
rtl/core/text_to_utf8_transcoder.sv
dv/tb.sv
